### hw/rtl/ray_triangle_closest_hit_assert.svh
// Assertion macros shared by the ray / triangle closest-hit RTL.
`ifndef RAY_TRIANGLE_CLOSEST_HIT_ASSERT_SVH
`define RAY_TRIANGLE_CLOSEST_HIT_ASSERT_SVH

// Check prop at every rising edge outside reset.
`define RTCH_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that cond never holds outside reset.
`define RTCH_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### hw/rtl/rtch_pkg.sv
// ----------------------------------------------------------------------------
// rtch_pkg
// Types and constants shared by the ray / triangle closest-hit block.
// ----------------------------------------------------------------------------
`default_nettype none

package rtch_pkg;

  localparam int COMPONENT_BITS_DEF = 21;
  localparam int TAG_BITS_DEF       = 16;

  localparam int VEC_W   = 63;
  localparam int LIMIT_W = 31;
  localparam int TAG_W   = 16;
  localparam int T_INT   = 15;
  localparam int T_FRAC  = 16;
  localparam int W_FRAC  = 16;
  localparam int Q_W     = T_INT + T_FRAC;
  localparam int STEP_W  = $clog2(Q_W + 1);

  localparam int QUEUE_DEPTH = 2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  typedef struct packed {
    logic               action;
    logic [VEC_W-1:0]   ray_origin;
    logic [VEC_W-1:0]   ray_direction;
    logic [LIMIT_W-1:0] near_t;
    logic [LIMIT_W-1:0] far_t;
    logic [VEC_W-1:0]   vertex_a;
    logic [VEC_W-1:0]   vertex_b;
    logic [VEC_W-1:0]   vertex_c;
    logic [VEC_W-1:0]   normal_a;
    logic [VEC_W-1:0]   normal_b;
    logic [VEC_W-1:0]   normal_c;
    logic [TAG_W-1:0]   triangle_tag;
  } request_t;

  typedef struct packed {
    logic               hit;
    logic [LIMIT_W-1:0] hit_t;
    logic [VEC_W-1:0]   hit_normal;
    logic [TAG_W-1:0]   hit_tag;
  } result_t;

  // Handshake between the request queue and its neighbors.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

### hw/rtl/ray_triangle_closest_hit.sv
// Ray / triangle closest-hit test, queue interface on both sides.
// Sequence: a load writes the result register as it leaves the queue; a test
// on a hit runs 24 products on one multiplier, a 31-bit t division and two
// 16-bit weight divisions, then 12 more products; a miss ends the sequence early.
// Throughput: one request at a time in the back end; the queue holds 2 more.
// Reset: synchronous rst clears the ray to zero and empties queue and result.
// ----------------------------------------------------------------------------
// ray_triangle_closest_hit
// Top level: front classifier, request queue and arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_triangle_closest_hit import rtch_pkg::*; #(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
  parameter int TAG_BITS       = TAG_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  output logic          full,
  input  wire request_t request,
  output logic          empty,
  input  wire logic     pop,
  output result_t       result
);

  queue_status_t q_status;
  logic          q_wr;
  request_t      q_data;
  logic          take;
  request_t      head;

  rtch_front #(
    .COMPONENT_BITS (COMPONENT_BITS),
    .TAG_BITS       (TAG_BITS)
  ) u_front (
    .push     (push),
    .request  (request),
    .full     (full),
    .q_status (q_status),
    .q_wr     (q_wr),
    .q_data   (q_data)
  );

  rtch_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_data (q_data),
    .rd      (take),
    .rd_data (head),
    .status  (q_status)
  );

  rtch_back #(
    .COMPONENT_BITS (COMPONENT_BITS),
    .TAG_BITS       (TAG_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .take     (take),
    .result   (result),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

`default_nettype wire

### hw/rtl/rtch_queue.sv
// ----------------------------------------------------------------------------
// rtch_queue
// Short request queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rtch_queue import rtch_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr,
  input  wire request_t      wr_data,
  input  wire logic          rd,
  output request_t           rd_data,
  output queue_status_t      status
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  request_t         slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_wr;
  logic do_rd;

  assign status.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign do_wr = wr && !status.full;
  assign do_rd = rd && !status.empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rtch_front.sv
// ----------------------------------------------------------------------------
// rtch_front
// Accepts requests, classifies loads and tests and trims unused fields.
// ----------------------------------------------------------------------------
`default_nettype none

module rtch_front import rtch_pkg::*; #(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
  parameter int TAG_BITS       = TAG_BITS_DEF
) (
  input  wire logic          push,
  input  wire request_t      request,
  output logic               full,
  input  wire queue_status_t q_status,
  output logic               q_wr,
  output request_t           q_data
);

  localparam int TAG_KEEP = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
  localparam logic [VEC_W-1:0] VEC_MASK =
    VEC_W'((65'(1) << (3 * COMPONENT_BITS)) - 65'(1));
  localparam logic [TAG_W-1:0] TAG_MASK =
    TAG_W'((33'(1) << TAG_KEEP) - 33'(1));

  assign full = q_status.full;
  assign q_wr = push && !q_status.full;

  always_comb begin
    q_data = '0;
    q_data.action = request.action;
    if (request.action == OP_LOAD) begin
      q_data.ray_origin    = request.ray_origin & VEC_MASK;
      q_data.ray_direction = request.ray_direction & VEC_MASK;
      q_data.near_t        = request.near_t;
      q_data.far_t         = request.far_t;
    end else begin
      q_data.vertex_a     = request.vertex_a & VEC_MASK;
      q_data.vertex_b     = request.vertex_b & VEC_MASK;
      q_data.vertex_c     = request.vertex_c & VEC_MASK;
      q_data.normal_a     = request.normal_a & VEC_MASK;
      q_data.normal_b     = request.normal_b & VEC_MASK;
      q_data.normal_c     = request.normal_c & VEC_MASK;
      q_data.triangle_tag = request.triangle_tag & TAG_MASK;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rtch_div.sv
// ----------------------------------------------------------------------------
// rtch_div
// Restoring fixed-point divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rtch_div import rtch_pkg::*; #(
  parameter int DEN_W = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [STEP_W-1:0] steps,
  input  wire logic [DEN_W-1:0]  den,
  input  wire logic [DEN_W-1:0]  rem0,
  input  wire logic [Q_W-1:0]    bits,
  output logic                   done,
  output logic [Q_W-1:0]         quo
);

  logic              busy;
  logic [STEP_W-1:0] cnt;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  dvs;
  logic [Q_W-1:0]    feed;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;

  // Remainder stays below the divisor, so the shifted trial fits one extra bit.
  assign trial = {rem, feed[Q_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= rem0;
      dvs  <= den;
      feed <= bits;
      quo  <= '0;
    end else if (busy) begin
      rem  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo  <= {quo[Q_W-2:0], ge};
      feed <= {feed[Q_W-2:0], 1'b0};
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rtch_back.sv
// ----------------------------------------------------------------------------
// rtch_back
// Holds the ray, runs one shared multiplier through a micro-sequence and the
// divider, and keeps the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rtch_back import rtch_pkg::*; #(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
  parameter int TAG_BITS       = TAG_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire request_t      head,
  input  wire queue_status_t q_status,
  output logic               take,
  output result_t            result,
  output logic               empty,
  input  wire logic          pop
);

  localparam int C        = COMPONENT_BITS;
  localparam int CS       = (3 * C > 57) ? 3 * C - 57 : 0;
  localparam int DIFF_W   = C + 1;
  localparam int A_W      = 2 * DIFF_W + 1 - CS;
  localparam int B_W      = (DIFF_W > W_FRAC + 2) ? DIFF_W : W_FRAC + 2;
  localparam int P_W      = A_W + B_W;
  localparam int ACC_W    = P_W + 2;
  localparam int TAG_KEEP = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MUL1   = 4'd1;
  localparam logic [3:0] ST_SIGN   = 4'd2;
  localparam logic [3:0] ST_CHECK  = 4'd3;
  localparam logic [3:0] ST_DIV_T  = 4'd4;
  localparam logic [3:0] ST_LIMIT  = 4'd5;
  localparam logic [3:0] ST_DIV_W1 = 4'd6;
  localparam logic [3:0] ST_DIV_W2 = 4'd7;
  localparam logic [3:0] ST_WSUM   = 4'd8;
  localparam logic [3:0] ST_MUL2   = 4'd9;
  localparam logic [3:0] ST_FIN    = 4'd10;

  localparam logic [2:0] A_D  = 3'd0;
  localparam logic [2:0] A_S  = 3'd1;
  localparam logic [2:0] A_S1 = 3'd2;
  localparam logic [2:0] A_S2 = 3'd3;
  localparam logic [2:0] A_N1 = 3'd4;
  localparam logic [2:0] A_N2 = 3'd5;
  localparam logic [2:0] A_N3 = 3'd6;
  localparam logic [2:0] A_NV = 3'd7;

  localparam logic [2:0] B_E1 = 3'd0;
  localparam logic [2:0] B_E2 = 3'd1;
  localparam logic [2:0] B_S  = 3'd2;
  localparam logic [2:0] B_D  = 3'd3;
  localparam logic [2:0] B_W0 = 3'd4;
  localparam logic [2:0] B_W1 = 3'd5;
  localparam logic [2:0] B_W2 = 3'd6;

  localparam logic [1:0] ACC_FIRST = 2'd0;
  localparam logic [1:0] ACC_ADD   = 2'd1;
  localparam logic [1:0] ACC_SUB   = 2'd2;

  localparam logic [3:0] DST_NONE = 4'd0;
  localparam logic [3:0] DST_S1   = 4'd1;
  localparam logic [3:0] DST_S2   = 4'd2;
  localparam logic [3:0] DST_DET  = 4'd3;
  localparam logic [3:0] DST_U    = 4'd4;
  localparam logic [3:0] DST_TN   = 4'd5;
  localparam logic [3:0] DST_V    = 4'd6;
  localparam logic [3:0] DST_NV   = 4'd7;
  localparam logic [3:0] DST_ND   = 4'd8;

  localparam logic [5:0] STEP_MUL1_END   = 6'd24;
  localparam logic [5:0] STEP_MUL2_BEGIN = 6'd24;
  localparam logic [5:0] STEP_MUL2_END   = 6'd36;

  typedef struct packed {
    logic [2:0] a_src;
    logic [1:0] a_idx;
    logic [2:0] b_src;
    logic [1:0] b_idx;
    logic [1:0] op;
    logic [3:0] dst;
    logic [1:0] d_idx;
  } uop_t;

  function automatic uop_t mk(input logic [2:0] asrc, input logic [1:0] aidx,
                              input logic [2:0] bsrc, input logic [1:0] bidx,
                              input logic [1:0] aop, input logic [3:0] dsel,
                              input logic [1:0] didx);
    uop_t r;
    r.a_src = asrc;
    r.a_idx = aidx;
    r.b_src = bsrc;
    r.b_idx = bidx;
    r.op    = aop;
    r.dst   = dsel;
    r.d_idx = didx;
    return r;
  endfunction

  // Cross products, the four dot products, then the normal blend and its
  // dot with the direction.
  function automatic uop_t ucode(input logic [5:0] st);
    uop_t r;
    r = mk(A_D, 2'd0, B_E1, 2'd0, ACC_FIRST, DST_NONE, 2'd0);
    unique case (st)
      6'd0:  r = mk(A_D,  2'd1, B_E2, 2'd2, ACC_FIRST, DST_NONE, 2'd0);
      6'd1:  r = mk(A_D,  2'd2, B_E2, 2'd1, ACC_SUB,   DST_S1,   2'd0);
      6'd2:  r = mk(A_D,  2'd2, B_E2, 2'd0, ACC_FIRST, DST_NONE, 2'd0);
      6'd3:  r = mk(A_D,  2'd0, B_E2, 2'd2, ACC_SUB,   DST_S1,   2'd1);
      6'd4:  r = mk(A_D,  2'd0, B_E2, 2'd1, ACC_FIRST, DST_NONE, 2'd0);
      6'd5:  r = mk(A_D,  2'd1, B_E2, 2'd0, ACC_SUB,   DST_S1,   2'd2);
      6'd6:  r = mk(A_S,  2'd1, B_E1, 2'd2, ACC_FIRST, DST_NONE, 2'd0);
      6'd7:  r = mk(A_S,  2'd2, B_E1, 2'd1, ACC_SUB,   DST_S2,   2'd0);
      6'd8:  r = mk(A_S,  2'd2, B_E1, 2'd0, ACC_FIRST, DST_NONE, 2'd0);
      6'd9:  r = mk(A_S,  2'd0, B_E1, 2'd2, ACC_SUB,   DST_S2,   2'd1);
      6'd10: r = mk(A_S,  2'd0, B_E1, 2'd1, ACC_FIRST, DST_NONE, 2'd0);
      6'd11: r = mk(A_S,  2'd1, B_E1, 2'd0, ACC_SUB,   DST_S2,   2'd2);
      6'd12: r = mk(A_S1, 2'd0, B_E1, 2'd0, ACC_FIRST, DST_NONE, 2'd0);
      6'd13: r = mk(A_S1, 2'd1, B_E1, 2'd1, ACC_ADD,   DST_NONE, 2'd0);
      6'd14: r = mk(A_S1, 2'd2, B_E1, 2'd2, ACC_ADD,   DST_DET,  2'd0);
      6'd15: r = mk(A_S1, 2'd0, B_S,  2'd0, ACC_FIRST, DST_NONE, 2'd0);
      6'd16: r = mk(A_S1, 2'd1, B_S,  2'd1, ACC_ADD,   DST_NONE, 2'd0);
      6'd17: r = mk(A_S1, 2'd2, B_S,  2'd2, ACC_ADD,   DST_U,    2'd0);
      6'd18: r = mk(A_S2, 2'd0, B_E2, 2'd0, ACC_FIRST, DST_NONE, 2'd0);
      6'd19: r = mk(A_S2, 2'd1, B_E2, 2'd1, ACC_ADD,   DST_NONE, 2'd0);
      6'd20: r = mk(A_S2, 2'd2, B_E2, 2'd2, ACC_ADD,   DST_TN,   2'd0);
      6'd21: r = mk(A_S2, 2'd0, B_D,  2'd0, ACC_FIRST, DST_NONE, 2'd0);
      6'd22: r = mk(A_S2, 2'd1, B_D,  2'd1, ACC_ADD,   DST_NONE, 2'd0);
      6'd23: r = mk(A_S2, 2'd2, B_D,  2'd2, ACC_ADD,   DST_V,    2'd0);
      6'd24: r = mk(A_N1, 2'd0, B_W0, 2'd0, ACC_FIRST, DST_NONE, 2'd0);
      6'd25: r = mk(A_N2, 2'd0, B_W1, 2'd0, ACC_ADD,   DST_NONE, 2'd0);
      6'd26: r = mk(A_N3, 2'd0, B_W2, 2'd0, ACC_ADD,   DST_NV,   2'd0);
      6'd27: r = mk(A_N1, 2'd1, B_W0, 2'd0, ACC_FIRST, DST_NONE, 2'd0);
      6'd28: r = mk(A_N2, 2'd1, B_W1, 2'd0, ACC_ADD,   DST_NONE, 2'd0);
      6'd29: r = mk(A_N3, 2'd1, B_W2, 2'd0, ACC_ADD,   DST_NV,   2'd1);
      6'd30: r = mk(A_N1, 2'd2, B_W0, 2'd0, ACC_FIRST, DST_NONE, 2'd0);
      6'd31: r = mk(A_N2, 2'd2, B_W1, 2'd0, ACC_ADD,   DST_NONE, 2'd0);
      6'd32: r = mk(A_N3, 2'd2, B_W2, 2'd0, ACC_ADD,   DST_NV,   2'd2);
      6'd33: r = mk(A_NV, 2'd0, B_D,  2'd0, ACC_FIRST, DST_NONE, 2'd0);
      6'd34: r = mk(A_NV, 2'd1, B_D,  2'd1, ACC_ADD,   DST_NONE, 2'd0);
      6'd35: r = mk(A_NV, 2'd2, B_D,  2'd2, ACC_ADD,   DST_ND,   2'd0);
      default: r = mk(A_D, 2'd0, B_E1, 2'd0, ACC_FIRST, DST_NONE, 2'd0);
    endcase
    return r;
  endfunction

  // Ray state
  logic signed [C-1:0]   ray_o [3];
  logic signed [C-1:0]   ray_d [3];
  logic [LIMIT_W-1:0]    near_limit;
  logic [LIMIT_W-1:0]    far_limit;

  // Triangle operands
  logic signed [DIFF_W-1:0] e1 [3];
  logic signed [DIFF_W-1:0] e2 [3];
  logic signed [DIFF_W-1:0] sv [3];
  logic signed [C-1:0]      n1 [3];
  logic signed [C-1:0]      n2 [3];
  logic signed [C-1:0]      n3 [3];
  logic [TAG_KEEP-1:0]      tag;

  // Intermediates
  logic signed [A_W-1:0]   s1 [3];
  logic signed [A_W-1:0]   s2 [3];
  logic signed [ACC_W-1:0] det;
  logic signed [ACC_W-1:0] tn;
  logic signed [ACC_W-1:0] u;
  logic signed [ACC_W-1:0] v;
  logic signed [ACC_W-1:0] ndot;
  logic signed [C-1:0]     nv [3];
  logic                    det_zero;
  logic [Q_W-1:0]          tq;
  logic [W_FRAC:0]         w0;
  logic [W_FRAC-1:0]       w1;
  logic [W_FRAC-1:0]       w2;

  // Control
  logic [3:0] state;
  logic [5:0] step;
  logic       res_valid;

  // Multiplier pipe
  uop_t                    cur;
  uop_t                    pend;
  logic                    pend_valid;
  logic                    issue;
  logic signed [A_W-1:0]   a_op;
  logic signed [B_W-1:0]   b_op;
  logic signed [P_W-1:0]   prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_next;

  // Divider
  logic              div_start;
  logic [STEP_W-1:0] div_steps;
  logic [ACC_W-1:0]  div_rem0;
  logic [Q_W-1:0]    div_bits;
  logic              div_done;
  logic [Q_W-1:0]    div_quo;

  // Decisions
  logic              res_free;
  logic              res_load;
  result_t           res_data;
  logic              check_miss;
  logic              limit_miss;
  logic signed [ACC_W-1:0] rest;
  logic              tn_big;
  logic signed [C-1:0] p1 [3];
  logic signed [C-1:0] p2 [3];
  logic signed [C-1:0] p3 [3];
  logic signed [C-1:0] nvo [3];

  assign res_free = !res_valid || pop;
  assign empty    = res_valid ? 1'b0 : 1'b1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p1[i] = $signed(head.vertex_a[i*C +: C]);
      p2[i] = $signed(head.vertex_b[i*C +: C]);
      p3[i] = $signed(head.vertex_c[i*C +: C]);
    end
  end

  // Operand selection for the shared multiplier
  assign cur   = ucode(step);
  assign issue = ((state == ST_MUL1) && (step < STEP_MUL1_END)) ||
                 ((state == ST_MUL2) && (step < STEP_MUL2_END));

  always_comb begin
    unique case (cur.a_src)
      A_D:     a_op = A_W'(ray_d[cur.a_idx]);
      A_S:     a_op = A_W'(sv[cur.a_idx]);
      A_S1:    a_op = s1[cur.a_idx];
      A_S2:    a_op = s2[cur.a_idx];
      A_N1:    a_op = A_W'(n1[cur.a_idx]);
      A_N2:    a_op = A_W'(n2[cur.a_idx]);
      A_N3:    a_op = A_W'(n3[cur.a_idx]);
      A_NV:    a_op = A_W'(nv[cur.a_idx]);
      default: a_op = '0;
    endcase
    unique case (cur.b_src)
      B_E1:    b_op = B_W'(e1[cur.b_idx]);
      B_E2:    b_op = B_W'(e2[cur.b_idx]);
      B_S:     b_op = B_W'(sv[cur.b_idx]);
      B_D:     b_op = B_W'(ray_d[cur.b_idx]);
      B_W0:    b_op = $signed(B_W'(w0));
      B_W1:    b_op = $signed(B_W'(w1));
      B_W2:    b_op = $signed(B_W'(w2));
      default: b_op = '0;
    endcase
  end

  always_comb begin
    unique case (pend.op)
      ACC_FIRST: acc_next = ACC_W'(prod);
      ACC_ADD:   acc_next = acc + ACC_W'(prod);
      ACC_SUB:   acc_next = acc - ACC_W'(prod);
      default:   acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      prod <= a_op * b_op;
      pend <= cur;
    end
    if (pend_valid) begin
      acc <= acc_next;
      unique case (pend.dst)
        DST_S1:  s1[pend.d_idx] <= A_W'(acc_next >>> CS);
        DST_S2:  s2[pend.d_idx] <= A_W'(acc_next >>> CS);
        DST_DET: det <= acc_next;
        DST_U:   u <= acc_next;
        DST_TN:  tn <= acc_next;
        DST_V:   v <= acc_next;
        DST_NV:  nv[pend.d_idx] <= C'(acc_next >>> W_FRAC);
        DST_ND:  ndot <= acc_next;
        default: begin
        end
      endcase
    end else if (state == ST_SIGN) begin
      // Fold the determinant sign into all four dot products.
      det_zero <= (det == '0);
      if (det[ACC_W-1]) begin
        det <= -det;
        tn  <= -tn;
        u   <= -u;
        v   <= -v;
      end
    end
  end

  // Barycentric and range screening ahead of the t division
  assign rest   = det - u - v;
  assign tn_big = ({{T_INT{1'b0}}, tn} >= {det, {T_INT{1'b0}}});
  assign check_miss = det_zero ||
                      u[ACC_W-1] || (u == '0) ||
                      v[ACC_W-1] || (v == '0) ||
                      rest[ACC_W-1] || (rest == '0) ||
                      tn[ACC_W-1] || tn_big;
  assign limit_miss = (tq < near_limit) || (tq > far_limit);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!ndot[ACC_W-1] && (ndot != '0)) begin
        nvo[i] = (nv[i] == {1'b1, {(C-1){1'b0}}}) ? {1'b0, {(C-1){1'b1}}} : -nv[i];
      end else begin
        nvo[i] = nv[i];
      end
    end
  end

  always_comb begin
    take      = 1'b0;
    res_load  = 1'b0;
    res_data  = '0;
    div_start = 1'b0;
    div_steps = STEP_W'(W_FRAC);
    div_rem0  = u;
    div_bits  = '0;
    unique case (state)
      ST_IDLE: begin
        if (!q_status.empty && res_free) begin
          take = 1'b1;
          res_load = (head.action == OP_LOAD);
        end
      end
      ST_CHECK: begin
        if (check_miss) begin
          res_load = 1'b1;
        end else begin
          div_start = 1'b1;
          div_steps = STEP_W'(Q_W);
          div_rem0  = tn >>> T_INT;
          div_bits  = {tn[T_INT-1:0], {T_FRAC{1'b0}}};
        end
      end
      ST_LIMIT: begin
        if (limit_miss) begin
          res_load = 1'b1;
        end else begin
          div_start = 1'b1;
        end
      end
      ST_DIV_W1: begin
        if (div_done) begin
          div_start = 1'b1;
          div_rem0  = v;
        end
      end
      ST_FIN: begin
        res_load = 1'b1;
        res_data.hit        = 1'b1;
        res_data.hit_t      = LIMIT_W'(tq);
        res_data.hit_normal = VEC_W'({nvo[2], nvo[1], nvo[0]});
        res_data.hit_tag    = TAG_W'(tag);
      end
      default: begin
        take = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step       <= '0;
      res_valid  <= 1'b0;
      near_limit <= '0;
      far_limit  <= '0;
      for (int i = 0; i < 3; i++) begin
        ray_o[i] <= '0;
        ray_d[i] <= '0;
      end
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            if (head.action == OP_LOAD) begin
              for (int i = 0; i < 3; i++) begin
                ray_o[i] <= $signed(head.ray_origin[i*C +: C]);
                ray_d[i] <= $signed(head.ray_direction[i*C +: C]);
              end
              near_limit <= head.near_t;
              far_limit  <= head.far_t;
            end else begin
              step  <= '0;
              state <= ST_MUL1;
            end
          end
        end
        ST_MUL1: begin
          step <= step + 1'b1;
          if (step == STEP_MUL1_END) begin
            state <= ST_SIGN;
          end
        end
        ST_SIGN:  state <= ST_CHECK;
        ST_CHECK: state <= check_miss ? ST_IDLE : ST_DIV_T;
        ST_DIV_T: begin
          if (div_done) begin
            state <= ST_LIMIT;
          end
        end
        ST_LIMIT: state <= limit_miss ? ST_IDLE : ST_DIV_W1;
        ST_DIV_W1: begin
          if (div_done) begin
            state <= ST_DIV_W2;
          end
        end
        ST_DIV_W2: begin
          if (div_done) begin
            state <= ST_WSUM;
          end
        end
        ST_WSUM: begin
          step  <= STEP_MUL2_BEGIN;
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          step <= step + 1'b1;
          if (step == STEP_MUL2_END) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          far_limit <= LIMIT_W'(tq);
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result <= res_data;
    end
    if (take && (head.action == OP_TEST)) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= DIFF_W'(p2[i]) - DIFF_W'(p1[i]);
        e2[i] <= DIFF_W'(p3[i]) - DIFF_W'(p1[i]);
        sv[i] <= DIFF_W'(ray_o[i]) - DIFF_W'(p1[i]);
        n1[i] <= $signed(head.normal_a[i*C +: C]);
        n2[i] <= $signed(head.normal_b[i*C +: C]);
        n3[i] <= $signed(head.normal_c[i*C +: C]);
      end
      tag <= head.triangle_tag[TAG_KEEP-1:0];
    end
    if (state == ST_DIV_T && div_done) begin
      tq <= div_quo;
    end
    if (state == ST_DIV_W1 && div_done) begin
      w1 <= div_quo[W_FRAC-1:0];
    end
    if (state == ST_DIV_W2 && div_done) begin
      w2 <= div_quo[W_FRAC-1:0];
    end
    if (state == ST_WSUM) begin
      w0 <= (W_FRAC+1)'(1 << W_FRAC) - (W_FRAC+1)'(w1) - (W_FRAC+1)'(w2);
    end
  end

  rtch_div #(
    .DEN_W (ACC_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .steps (div_steps),
    .den   (det),
    .rem0  (div_rem0),
    .bits  (div_bits),
    .done  (div_done),
    .quo   (div_quo)
  );

`include "ray_triangle_closest_hit_assert.svh"

  `RTCH_ASSERT(a_div_done_state, clk, rst,
    div_done |-> (state == ST_DIV_T || state == ST_DIV_W1 || state == ST_DIV_W2),
    "divider finished outside a divide state")
  `RTCH_ASSERT(a_take_idle, clk, rst,
    take |-> (state == ST_IDLE && !q_status.empty), "request taken while busy")
  `RTCH_ASSERT(a_res_slot_free, clk, rst,
    res_load |-> res_free, "result overwritten before it was taken")
  `RTCH_NEVER(a_mul_busy_idle, clk, rst,
    issue && (state == ST_IDLE), "multiplier issued while idle")

endmodule

`default_nettype wire
